>>> hdl/sorted_string_insert_table_core_defines.svh
// Assertion macros for the sorted name table core
`ifndef SORTED_STRING_INSERT_TABLE_CORE_DEFINES_SVH
`define SORTED_STRING_INSERT_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SSIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ssit_pkg.sv
// Shared types and constants for the sorted name table
package ssit_pkg;

  localparam int LIST_ENTRIES_DEF = 128;
  localparam int NAME_CHARS_DEF   = 64;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int STATUS_W   = 3;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TRUNCATED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ_OK   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_OOR  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH_WAIT,
    ST_SRCH_EVAL,
    ST_SH_INIT,
    ST_SH_CHK,
    ST_SH_WAIT,
    ST_SH_WR,
    ST_NW_WAIT,
    ST_NW_WR,
    ST_RESP
  } ssit_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SRCH_INIT,
    CMD_NEXT_CHAR,
    CMD_NEXT_ENTRY,
    CMD_SH_INIT,
    CMD_SH_START,
    CMD_SH_WRITE,
    CMD_NW_START,
    CMD_NW_WRITE,
    CMD_RESP
  } ssit_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_last;
    logic full;
    logic cnt_zero;
    logic k_last;
    logic i_at_n;
    logic chars_differ;
    logic pend_less;
    logic j_at_k;
    logic col_last;
    logic nw_last;
  } ssit_stat_t;

endpackage

>>> hdl/sorted_string_insert_table_core.sv
// Top level of the sorted name table core
//
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tdata: char_code, entry_index, char_index; tlast; tuser=mode
// out     | out | out_tvalid/tready  | tdata: position, entry_count, read_char; tuser=status
//
// Non-final character: accept, then dispatch. Read: accept, dispatch and result, plus output stall.
// Insert: a wait and an evaluate state per character compared while searching; per entry shifted
// up, a check then a wait and a write state per character; a wait and a write per character written.
// Reset is synchronous; stores need no clearing, so items are taken right after reset.
// A finished result holds in the output register while the next item is accepted.
module sorted_string_insert_table_core #(
  parameter int LIST_ENTRIES = ssit_pkg::LIST_ENTRIES_DEF,
  parameter int NAME_CHARS   = ssit_pkg::NAME_CHARS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] char_code, [14:8] entry_index, [20:15] char_index, [23:21] zero
  input  logic [ssit_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  // [0] mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [6:0] position, [14:7] entry_count, [22:15] read_char, [23] zero
  output logic [ssit_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] status
  output logic [ssit_pkg::STATUS_W-1:0]      out_tuser
);

  ssit_pkg::ssit_cmd_t  cmd;
  ssit_pkg::ssit_stat_t stat;

  ssit_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  ssit_dp #(.LIST_ENTRIES(LIST_ENTRIES), .NAME_CHARS(NAME_CHARS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .in_tuser(in_tuser), .stat(stat), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

>>> hdl/ssit_ram.sv
// Generic simple dual-port RAM with registered read
module ssit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ssit_dp.sv
// Datapath: name buffer, list store, lengths, counters and result register
module ssit_dp #(
  parameter int LIST_ENTRIES = ssit_pkg::LIST_ENTRIES_DEF,
  parameter int NAME_CHARS   = ssit_pkg::NAME_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssit_pkg::ssit_cmd_t               cmd,
  input  logic [ssit_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tuser,
  output ssit_pkg::ssit_stat_t              stat,
  output logic [ssit_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [ssit_pkg::STATUS_W-1:0]     out_tuser
);

  localparam int CW  = $clog2(NAME_CHARS);
  localparam int LW  = $clog2(NAME_CHARS + 1);
  localparam int EW  = $clog2(LIST_ENTRIES);
  localparam int NCW = $clog2(LIST_ENTRIES + 1);

  logic          is_read_r, last_r, shifting_r, ovf_r;
  logic [6:0]    eidx_r;
  logic [5:0]    cidx_r;
  logic [LW-1:0] newlen_r;
  logic [NCW-1:0] cnt_r;
  logic [EW-1:0] k_r, j_r;
  logic [LW-1:0] i_r;
  logic [ssit_pkg::STATUS_W-1:0] o_stat_r;
  logic [6:0]    o_pos_r;
  logic [7:0]    o_cnt_r, o_char_r;

  logic [7:0]    buf_dout, st_dout;
  logic [LW-1:0] len_dout;
  logic          buf_we, st_we, len_we;
  logic [CW-1:0] buf_waddr;
  logic [EW+CW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata;
  logic [EW-1:0] len_waddr, len_raddr, row_rd;
  logic [LW-1:0] len_wdata, n_min;
  logic          read_oor;

  always_comb begin
    row_rd    = shifting_r ? (j_r - EW'(1)) : (is_read_r ? EW'(eidx_r) : k_r);
    st_raddr  = {row_rd, is_read_r ? CW'(cidx_r) : CW'(i_r)};
    len_raddr = row_rd;
    buf_we    = (cmd == ssit_pkg::CMD_ACCEPT) && !in_tuser &&
                (32'(newlen_r) < NAME_CHARS);
    buf_waddr = CW'(newlen_r);
    st_we     = (cmd == ssit_pkg::CMD_SH_WRITE) || (cmd == ssit_pkg::CMD_NW_WRITE);
    st_waddr  = (cmd == ssit_pkg::CMD_SH_WRITE) ? {j_r, CW'(i_r)} : {k_r, CW'(i_r)};
    st_wdata  = (cmd == ssit_pkg::CMD_SH_WRITE) ? st_dout : buf_dout;
    len_we    = ((cmd == ssit_pkg::CMD_SH_WRITE) && (i_r == '0)) ||
                ((cmd == ssit_pkg::CMD_NW_WRITE) && (i_r + LW'(1) == newlen_r));
    len_waddr = (cmd == ssit_pkg::CMD_SH_WRITE) ? j_r : k_r;
    len_wdata = (cmd == ssit_pkg::CMD_SH_WRITE) ? len_dout : newlen_r;
    n_min     = (newlen_r < len_dout) ? newlen_r : len_dout;
    read_oor  = (32'(eidx_r) >= 32'(cnt_r)) || (32'(cidx_r) >= NAME_CHARS);

    stat.is_read      = is_read_r;
    stat.is_last      = last_r;
    stat.full         = (32'(cnt_r) >= LIST_ENTRIES);
    stat.cnt_zero     = (cnt_r == '0);
    stat.k_last       = (NCW'(k_r) + NCW'(1) == cnt_r);
    stat.i_at_n       = (i_r == n_min);
    stat.chars_differ = (buf_dout != st_dout);
    stat.pend_less    = (i_r == n_min) ? (newlen_r < len_dout) : (buf_dout < st_dout);
    stat.j_at_k       = (j_r == k_r);
    stat.col_last     = (32'(i_r) == NAME_CHARS - 1);
    stat.nw_last      = (i_r + LW'(1) == newlen_r);
  end

  ssit_ram #(.WIDTH(8), .DEPTH(NAME_CHARS)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(in_tdata[7:0]),
    .raddr(CW'(i_r)), .rdata(buf_dout)
  );

  ssit_ram #(.WIDTH(8), .DEPTH(LIST_ENTRIES << CW)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_dout)
  );

  ssit_ram #(.WIDTH(LW), .DEPTH(LIST_ENTRIES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_dout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newlen_r   <= '0;
      ovf_r      <= 1'b0;
      cnt_r      <= '0;
      shifting_r <= 1'b0;
      is_read_r  <= 1'b0;
    end else begin
      unique case (cmd)
        ssit_pkg::CMD_ACCEPT: begin
          is_read_r <= in_tuser;
          last_r    <= in_tlast;
          eidx_r    <= in_tdata[14:8];
          cidx_r    <= in_tdata[20:15];
          if (!in_tuser) begin
            if (32'(newlen_r) < NAME_CHARS) begin
              newlen_r <= newlen_r + LW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ssit_pkg::CMD_SRCH_INIT: begin
          k_r <= '0;
          i_r <= '0;
        end
        ssit_pkg::CMD_NEXT_CHAR: i_r <= i_r + LW'(1);
        ssit_pkg::CMD_NEXT_ENTRY: begin
          k_r <= k_r + EW'(1);
          i_r <= '0;
        end
        ssit_pkg::CMD_SH_INIT: begin
          j_r        <= EW'(cnt_r);
          shifting_r <= 1'b1;
        end
        ssit_pkg::CMD_SH_START: i_r <= '0;
        ssit_pkg::CMD_SH_WRITE: begin
          if (stat.col_last) begin
            j_r <= j_r - EW'(1);
          end else begin
            i_r <= i_r + LW'(1);
          end
        end
        ssit_pkg::CMD_NW_START: begin
          i_r        <= '0;
          shifting_r <= 1'b0;
        end
        ssit_pkg::CMD_NW_WRITE: i_r <= i_r + LW'(1);
        ssit_pkg::CMD_RESP: begin
          o_pos_r  <= 7'd0;
          o_char_r <= 8'd0;
          o_cnt_r  <= 8'(cnt_r);
          if (is_read_r) begin
            if (read_oor) begin
              o_stat_r <= ssit_pkg::STAT_READ_OOR;
            end else begin
              o_stat_r <= ssit_pkg::STAT_READ_OK;
              o_char_r <= (LW'(cidx_r) < len_dout) ? st_dout : 8'd0;
            end
          end else begin
            newlen_r <= '0;
            ovf_r    <= 1'b0;
            if (stat.full) begin
              o_stat_r <= ssit_pkg::STAT_FULL;
            end else begin
              o_stat_r <= ovf_r ? ssit_pkg::STAT_TRUNCATED : ssit_pkg::STAT_INSERTED;
              o_pos_r  <= 7'(k_r);
              o_cnt_r  <= 8'(cnt_r + NCW'(1));
              cnt_r    <= cnt_r + NCW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tdata = {1'b0, o_char_r, o_cnt_r, o_pos_r};
  assign out_tuser = o_stat_r;

endmodule

>>> hdl/ssit_ctrl.sv
// Controller: sequencing of accept, search, shift, write and result
`include "sorted_string_insert_table_core_defines.svh"
module ssit_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  ssit_pkg::ssit_stat_t  stat,
  output ssit_pkg::ssit_cmd_t   cmd
);

  ssit_pkg::ssit_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssit_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = ssit_pkg::CMD_NONE;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ssit_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = ssit_pkg::CMD_ACCEPT;
          state_nxt = ssit_pkg::ST_DISPATCH;
        end
      end
      ssit_pkg::ST_DISPATCH: begin
        if (stat.is_read || stat.full) begin
          state_nxt = stat.is_read || stat.is_last ? ssit_pkg::ST_RESP : ssit_pkg::ST_IDLE;
        end else if (!stat.is_last) begin
          state_nxt = ssit_pkg::ST_IDLE;
        end else begin
          cmd       = ssit_pkg::CMD_SRCH_INIT;
          state_nxt = stat.cnt_zero ? ssit_pkg::ST_SH_INIT : ssit_pkg::ST_SRCH_WAIT;
        end
      end
      ssit_pkg::ST_SRCH_WAIT: state_nxt = ssit_pkg::ST_SRCH_EVAL;
      ssit_pkg::ST_SRCH_EVAL: begin
        if (stat.i_at_n || stat.chars_differ) begin
          if (stat.pend_less) begin
            state_nxt = ssit_pkg::ST_SH_INIT;
          end else begin
            cmd       = ssit_pkg::CMD_NEXT_ENTRY;
            state_nxt = stat.k_last ? ssit_pkg::ST_SH_INIT : ssit_pkg::ST_SRCH_WAIT;
          end
        end else begin
          cmd       = ssit_pkg::CMD_NEXT_CHAR;
          state_nxt = ssit_pkg::ST_SRCH_WAIT;
        end
      end
      ssit_pkg::ST_SH_INIT: begin
        cmd       = ssit_pkg::CMD_SH_INIT;
        state_nxt = ssit_pkg::ST_SH_CHK;
      end
      ssit_pkg::ST_SH_CHK: begin
        if (stat.j_at_k) begin
          cmd       = ssit_pkg::CMD_NW_START;
          state_nxt = ssit_pkg::ST_NW_WAIT;
        end else begin
          cmd       = ssit_pkg::CMD_SH_START;
          state_nxt = ssit_pkg::ST_SH_WAIT;
        end
      end
      ssit_pkg::ST_SH_WAIT: state_nxt = ssit_pkg::ST_SH_WR;
      ssit_pkg::ST_SH_WR: begin
        cmd       = ssit_pkg::CMD_SH_WRITE;
        state_nxt = stat.col_last ? ssit_pkg::ST_SH_CHK : ssit_pkg::ST_SH_WAIT;
      end
      ssit_pkg::ST_NW_WAIT: state_nxt = ssit_pkg::ST_NW_WR;
      ssit_pkg::ST_NW_WR: begin
        cmd       = ssit_pkg::CMD_NW_WRITE;
        state_nxt = stat.nw_last ? ssit_pkg::ST_RESP : ssit_pkg::ST_NW_WAIT;
      end
      ssit_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd           = ssit_pkg::CMD_RESP;
          out_valid_nxt = 1'b1;
          state_nxt     = ssit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssit_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

  `SSIT_ASSERT_NXT(a_accept_dispatch, in_tvalid && in_tready, state_r == ssit_pkg::ST_DISPATCH, "accept not followed by dispatch")
  `SSIT_ASSERT_NXT(a_resp_valid, cmd == ssit_pkg::CMD_RESP, out_valid_r, "result load did not raise valid")
  `SSIT_ASSERT_IMP(a_valid_src, $rose(out_valid_r), $past(state_r) == ssit_pkg::ST_RESP, "valid rose outside result state")
  `SSIT_ASSERT_IMP(a_no_write_full, cmd == ssit_pkg::CMD_NW_WRITE, !stat.full, "insert write with full list")

endmodule

>>> tb/sv/sorted_string_insert_table_core_tb.sv
// Testbench for the sorted name table core: random streams checked against a local predictor
`timescale 1ns / 100ps

module sorted_string_insert_table_core_tb;

  localparam int ENTRIES = 128;
  localparam int CHARS = 64;
  localparam int WDOG_LIMIT = 200000;

  typedef struct {
    logic       mode;
    logic [7:0] code;
    logic       last;
    logic [6:0] eidx;
    logic [5:0] cidx;
    bit         drain;
  } name_item_t;

  typedef struct {
    logic [ssit_pkg::STATUS_W-1:0] status;
    logic [6:0]          position;
    logic [7:0]          count;
    logic [7:0]          rchar;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ssit_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ssit_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [ssit_pkg::STATUS_W-1:0] out_tuser;

  name_item_t    pending_items[$];
  table_result_t expected_results[$];

  logic [7:0] tbl_chars[ENTRIES][CHARS];
  int         tbl_len[ENTRIES];
  int         tbl_count;
  logic [7:0] name_buf[CHARS];
  int         name_len;
  bit         name_ovf;

  int  errors;
  int  gap_left;
  int  burst_left;
  int  idle_cycles;
  int  stall_phase;
  int  stall_pct;
  bit  stim_done = 1'b0;
  int  gen_inserts;
  int  gen_items;

  sorted_string_insert_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit name_sorts_before(int e);
    int n;
    n = (name_len < tbl_len[e]) ? name_len : tbl_len[e];
    for (int i = 0; i < n; i++) begin
      if (name_buf[i] != tbl_chars[e][i]) return name_buf[i] < tbl_chars[e][i];
    end
    return name_len < tbl_len[e];
  endfunction

  function automatic void predict_table(name_item_t it);
    table_result_t r;
    int k;
    r = '{status: ssit_pkg::STAT_INSERTED, position: '0, count: '0, rchar: '0};
    if (it.mode) begin
      if (it.eidx >= tbl_count) begin
        r.status = ssit_pkg::STAT_READ_OOR;
      end else begin
        r.status = ssit_pkg::STAT_READ_OK;
        if (it.cidx < tbl_len[it.eidx]) r.rchar = tbl_chars[it.eidx][it.cidx];
      end
      r.count = tbl_count[7:0];
      expected_results.push_back(r);
      return;
    end
    if (name_len < CHARS) begin
      name_buf[name_len] = it.code;
      name_len++;
    end else begin
      name_ovf = 1'b1;
    end
    if (!it.last) return;
    if (tbl_count >= ENTRIES) begin
      r.status = ssit_pkg::STAT_FULL;
    end else begin
      k = 0;
      while (k < tbl_count && !name_sorts_before(k)) k++;
      for (int j = tbl_count; j > k; j--) begin
        tbl_chars[j] = tbl_chars[j-1];
        tbl_len[j] = tbl_len[j-1];
      end
      tbl_chars[k] = name_buf;
      tbl_len[k] = name_len;
      tbl_count++;
      r.status = name_ovf ? ssit_pkg::STAT_TRUNCATED : ssit_pkg::STAT_INSERTED;
      r.position = k[6:0];
    end
    r.count = tbl_count[7:0];
    expected_results.push_back(r);
    name_len = 0;
    name_ovf = 1'b0;
  endfunction

  task automatic add_char(logic [7:0] code, logic last);
    pending_items.push_back('{mode: 1'b0, code: code, last: last, eidx: 7'($urandom),
                              cidx: 6'($urandom), drain: 1'b0});
    gen_items++;
    if (last) gen_inserts++;
  endtask

  task automatic add_read(logic [6:0] eidx, logic [5:0] cidx);
    pending_items.push_back('{mode: 1'b1, code: 8'($urandom), last: 1'($urandom),
                              eidx: eidx, cidx: cidx, drain: 1'b0});
    gen_items++;
  endtask

  task automatic add_drain();
    pending_items.push_back('{mode: 1'b0, code: '0, last: 1'b0, eidx: '0, cidx: '0,
                              drain: 1'b1});
  endtask

  function automatic logic [7:0] rand_char();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(97, 99)) : 8'($urandom);
  endfunction

  task automatic add_random_name();
    int len;
    int sel;
    sel = $urandom_range(0, 99);
    len = (sel < 3) ? $urandom_range(63, 70) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_read(7'($urandom), 6'($urandom));
      add_char(rand_char(), i == len - 1);
    end
  endtask

  // stimulus
  initial begin
    int cap;
    gen_items = 0;
    gen_inserts = 0;
    add_read(7'd0, 6'd0);
    add_char(8'h62, 1'b0);
    add_char(8'h62, 1'b1);
    add_char(8'h62, 1'b1);
    add_char(8'h61, 1'b0);
    add_char(8'h00, 1'b1);
    add_char(8'hff, 1'b1);
    add_char(8'h00, 1'b1);
    add_char(8'h62, 1'b0);
    add_read(7'd1, 6'd0);
    add_char(8'h62, 1'b1);
    add_char(8'h61, 1'b1);
    add_read(7'd0, 6'd0);
    add_read(7'd2, 6'd1);
    add_read(7'd2, 6'd63);
    add_read(7'd6, 6'd0);
    add_read(7'd127, 6'd5);
    add_read(7'd7, 6'd0);
    add_drain();
    while (gen_items < 1850) begin
      if ($urandom_range(0, 2) == 0) begin
        cap = (gen_inserts < ENTRIES) ? gen_inserts : ENTRIES;
        if ($urandom_range(0, 3) == 0) add_read(7'($urandom), 6'($urandom));
        else add_read(7'($urandom_range(0, cap)), 6'($urandom_range(0, 5)));
      end else begin
        add_random_name();
      end
      if ($urandom_range(0, 299) == 0) add_drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    errors = 0;
    tbl_count = 0;
    name_len = 0;
    name_ovf = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender
  always @(posedge clk) begin
    bit fire;
    name_item_t it;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      gap_left <= 0;
      burst_left <= $urandom_range(1, 20);
    end else begin
      if (fire) predict_table('{mode: in_tuser, code: in_tdata[7:0], last: in_tlast,
                                eidx: in_tdata[14:8], cidx: in_tdata[20:15], drain: 1'b0});
      if (!in_tvalid || fire) begin
        while (pending_items.size() > 0 && pending_items[0].drain &&
               expected_results.size() == 0)
          void'(pending_items.pop_front());
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !pending_items[0].drain) begin
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.mode;
          in_tlast <= it.last;
          in_tdata <= {3'b000, it.cidx, it.eidx, it.code};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
      stall_pct <= 0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase <= $urandom_range(50, 600);
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        stall_phase <= stall_phase - 1;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time, out_tuser, out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
            errors++;
          end
          if (out_tdata[6:0] !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     out_tdata[6:0]);
            errors++;
          end
          if (out_tdata[14:7] !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     out_tdata[14:7]);
            errors++;
          end
          if (out_tdata[22:15] !== want.rchar) begin
            $display("%0t: read_char expected %h actual %h", $time, want.rchar,
                     out_tdata[22:15]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("sorted_string_insert_table_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (stim_done);
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("sorted_string_insert_table_core: match");
    end else begin
      $display("sorted_string_insert_table_core: mismatch");
    end
    $finish;
  end

endmodule
